### rtl/ssmr_pkg.sv
package ssmr_pkg;

    localparam int ANGLE_FRAC_BITS = 24;
    localparam int ANGLE_W         = 32;
    localparam int CFG_W           = 28;
    localparam int STEP_W          = 25;
    localparam int RANGE_W         = 16;
    localparam int CM_W            = 8;
    localparam int CODE_W          = 4;
    localparam int NUM_SECTORS     = 10;
    localparam int SLOT_W          = $clog2(NUM_SECTORS);
    localparam int CNT_W           = $clog2(NUM_SECTORS);

    // queue between front and back
    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

    localparam logic [RANGE_W-1:0] MIN_RESET = {RANGE_W{1'b1}};

    typedef enum logic [1:0] {
        CFG_START = 2'd0,
        CFG_STEP  = 2'd1,
        CFG_STOP  = 2'd2
    } cfg_index_t;

    // k * pi/6 in fixed point, pi taken as 3.141592, rounded to nearest
    function automatic longint sixth_pi(input longint k);
        longint num;
        num = (k * 64'd3141592) << ANGLE_FRAC_BITS;
        return (num + 64'd3000000) / 64'd6000000;
    endfunction

    localparam logic signed [ANGLE_W-1:0] P1 = ANGLE_W'(sixth_pi(1));
    localparam logic signed [ANGLE_W-1:0] P2 = ANGLE_W'(sixth_pi(2));
    localparam logic signed [ANGLE_W-1:0] P3 = ANGLE_W'(sixth_pi(3));
    localparam logic signed [ANGLE_W-1:0] P4 = ANGLE_W'(sixth_pi(4));

    localparam logic [CODE_W-1:0] SECTOR_CODE [NUM_SECTORS] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd10, 4'd11
    };

    // One classified sample on its way from front to back
    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic [RANGE_W-1:0] range_mm;
        logic               update;
        logic               last;
    } work_t;

    // floor(mm / 10) saturated at 255; below 2560 the reciprocal 6554 / 2^16 is exact
    function automatic logic [CM_W-1:0] mm_to_cm(input logic [RANGE_W-1:0] mm);
        logic [24:0] prod;
        prod = 25'(mm[11:0]) * 25'd6554;
        if (mm >= 16'd2560)
            return {CM_W{1'b1}};
        return prod[23:16];
    endfunction

endpackage

### rtl/ssmr_in_if.sv
interface ssmr_in_if;
    logic                          valid;
    logic                          ready;
    logic [ssmr_pkg::RANGE_W-1:0]  range_mm;
    logic                          last_sample;

    modport source (output valid, output range_mm, output last_sample, input ready);
    modport sink   (input valid, input range_mm, input last_sample, output ready);
endinterface

### rtl/ssmr_out_if.sv
interface ssmr_out_if;
    logic                          valid;
    logic                          ready;
    logic [ssmr_pkg::CODE_W-1:0]   sector;
    logic [ssmr_pkg::CM_W-1:0]     distance_cm;
    logic                          last;

    modport source (output valid, output sector, output distance_cm, output last, input ready);
    modport sink   (input valid, input sector, input distance_cm, input last, output ready);
endinterface

### rtl/ssmr_front.sv
module ssmr_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_index,
    input  logic [ssmr_pkg::CFG_W-1:0]   cfg_data,
    ssmr_in_if.sink                      samples,
    output logic                         push_valid,
    input  logic                         push_ready,
    output ssmr_pkg::work_t              push_data
);
    import ssmr_pkg::*;

    logic signed [CFG_W-1:0]   start_reg, start_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic signed [CFG_W-1:0]   stop_reg, stop_next;
    logic signed [ANGLE_W-1:0] beam_reg, beam_next;

    logic                      accept;
    logic                      in_window;
    logic [SLOT_W-1:0]         slot;

    function automatic logic [SLOT_W-1:0] sector_slot(input logic signed [ANGLE_W-1:0] a);
        if (a <= -P4) return SLOT_W'(7);
        if (a <= -P3) return SLOT_W'(6);
        if (a <= -P2) return SLOT_W'(5);
        if (a <= -P1) return SLOT_W'(4);
        if (a <= 0)   return SLOT_W'(3);
        if (a <= P1)  return SLOT_W'(2);
        if (a <= P2)  return SLOT_W'(1);
        if (a <= P3)  return SLOT_W'(0);
        if (a <= P4)  return SLOT_W'(9);
        return SLOT_W'(8);
    endfunction

    assign accept        = samples.valid && push_ready;
    assign samples.ready = push_ready;
    assign push_valid    = samples.valid;
    assign in_window     = beam_reg < ANGLE_W'(stop_reg);
    assign slot          = sector_slot(beam_reg);

    always_comb
    begin
        push_data.slot     = slot;
        push_data.range_mm = samples.range_mm;
        push_data.update   = in_window;
        push_data.last     = samples.last_sample;
    end

    always_comb
    begin
        start_next = start_reg;
        step_next  = step_reg;
        stop_next  = stop_reg;
        beam_next  = beam_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_START:
                begin
                    start_next = cfg_data;
                    beam_next  = ANGLE_W'(signed'(cfg_data));
                end
                CFG_STEP:  step_next = cfg_data[STEP_W-1:0];
                CFG_STOP:  stop_next = cfg_data;
                default:   ;
            endcase
        end
        if (accept)
        begin
            // restart the scan on the last word, else advance while inside the window
            if (samples.last_sample)
                beam_next = ANGLE_W'(start_reg);
            else if (in_window)
                beam_next = beam_reg + signed'(ANGLE_W'(step_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= -28'sd38065825;
            step_reg  <= 25'd73204;
            stop_reg  <= 28'sd38065825;
            beam_reg  <= -32'sd38065825;
        end
        else
        begin
            start_reg <= start_next;
            step_reg  <= step_next;
            stop_reg  <= stop_next;
            beam_reg  <= beam_next;
        end
    end

endmodule

### rtl/ssmr_queue.sv
module ssmr_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  ssmr_pkg::work_t  push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output ssmr_pkg::work_t  pop_data
);
    import ssmr_pkg::*;

    work_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push, pop;

    assign push_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + QPTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + QPTR_W'(1);
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_full_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == QCNT_W'(QUEUE_DEPTH)) && !pop |=> count_reg == QCNT_W'(QUEUE_DEPTH))
        else $error("queue lost an entry while full");

endmodule

### rtl/ssmr_back.sv
module ssmr_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  ssmr_pkg::work_t  pop_data,
    ssmr_out_if.source       results
);
    import ssmr_pkg::*;

    typedef enum logic [1:0] {
        ST_RUN   = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [RANGE_W-1:0] min_reg [NUM_SECTORS];
    logic [RANGE_W-1:0] min_next [NUM_SECTORS];

    logic               out_valid_reg, out_valid_next;
    logic [CODE_W-1:0]  out_sector_reg, out_sector_next;
    logic [CM_W-1:0]    out_cm_reg, out_cm_next;
    logic               out_last_reg, out_last_next;

    logic               pop;
    logic               load;

    assign pop_ready = state_reg == ST_RUN;
    assign pop       = pop_valid && pop_ready;
    assign load      = (state_reg == ST_DRAIN) && (!out_valid_reg || results.ready);

    assign results.valid       = out_valid_reg;
    assign results.sector      = out_sector_reg;
    assign results.distance_cm = out_cm_reg;
    assign results.last        = out_last_reg;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        min_next        = min_reg;
        out_valid_next  = out_valid_reg && !results.ready;
        out_sector_next = out_sector_reg;
        out_cm_next     = out_cm_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            ST_RUN:
            begin
                if (pop)
                begin
                    if (pop_data.update && (pop_data.range_mm < min_reg[pop_data.slot]))
                        min_next[pop_data.slot] = pop_data.range_mm;
                    if (pop_data.last)
                    begin
                        state_next = ST_DRAIN;
                        cnt_next   = '0;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (load)
                begin
                    out_valid_next  = 1'b1;
                    out_sector_next = SECTOR_CODE[cnt_reg];
                    out_cm_next     = mm_to_cm(min_reg[0]);
                    out_last_next   = cnt_reg == CNT_W'(NUM_SECTORS - 1);
                    // shift the minima down, refilling the top with the empty value
                    for (int i = 0; i < NUM_SECTORS - 1; i++)
                        min_next[i] = min_reg[i+1];
                    min_next[NUM_SECTORS-1] = MIN_RESET;
                    if (cnt_reg == CNT_W'(NUM_SECTORS - 1))
                        state_next = ST_RUN;
                    else
                        cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_SECTORS; i++)
                min_reg[i] <= MIN_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            min_reg       <= min_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_sector_reg <= out_sector_next;
        out_cm_reg     <= out_cm_next;
        out_last_reg   <= out_last_next;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(NUM_SECTORS - 1))
        else $error("drain count out of range");

    a_last_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_last_reg |-> out_sector_reg == SECTOR_CODE[NUM_SECTORS-1])
        else $error("last result carries wrong sector");

    a_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
        load && (cnt_reg == CNT_W'(NUM_SECTORS - 1))
        |=> state_reg == ST_RUN && min_reg[0] == MIN_RESET)
        else $error("minima not cleared at end of drain");

endmodule

### rtl/scan_sector_min_range.sv
// Laser scan sector minimum. Range words are accepted while the queue is not full and
// may then stream at one per cycle: a front stage tracks the beam angle and sorts the
// sample into one of ten sectors, and a two-entry queue carries it to a back stage that
// keeps the per-sector minimum. A word marked last_sample makes the back stage emit ten
// result words, one per cycle through its output register while the receiver is ready,
// sectors 0..7, 10 and 11 in that order, each the minimum in centimetres saturated at
// 255; during this drain the front keeps accepting until the queue fills. The minima
// sit in flip-flops cleared as they drain, so no clearing pass is needed. Configuration
// (index 0 start angle, 1 step, 2 stop angle) is to be written by the user while idle,
// which the block does not enforce; writing the start angle also restarts the beam angle.
module scan_sector_min_range (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [ssmr_pkg::CFG_W-1:0]  cfg_data,
    ssmr_in_if.sink                     samples,
    ssmr_out_if.source                  results
);
    import ssmr_pkg::*;

    logic  push_valid, push_ready;
    work_t push_data;
    logic  pop_valid, pop_ready;
    work_t pop_data;

    ssmr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .samples    (samples),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    ssmr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    ssmr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .results    (results)
    );

endmodule
